// ===== rtl/bsrs_pkg.sv =====
// Package for the bucketed sorted record store: sizes, commands, status codes.
// No dependencies.
`default_nettype none
package bsrs_pkg;
  localparam int BUCKET_BITS = 8;
  localparam int BUCKET_CAP  = 64;
  localparam int KEY_BYTES   = 9;
  localparam int KEY_BITS    = KEY_BYTES * 8;
  localparam int SLOT_BITS   = $clog2(BUCKET_CAP);
  localparam int CNT_BITS    = $clog2(BUCKET_CAP + 1);
  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int ORD_ABITS   = BUCKET_BITS + SLOT_BITS;
  localparam int REC_ABITS   = BUCKET_BITS + SLOT_BITS + 2;
  localparam int REC_BITS    = 256;

  localparam logic [1:0] CMD_FIND  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_FOA   = 2'd2;
  // Unused command code; it behaves exactly as find.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_ADDED = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Result of one unsigned key compare of stored key against item key.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;
endpackage
`default_nettype wire

// ===== rtl/bsrs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bsrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/bsrs_keycmp.sv =====
// Key comparator: compares the leading key bits of two records.
// Depends on bsrs_pkg.
`default_nettype none
module bsrs_keycmp (
  input  wire logic [bsrs_pkg::REC_BITS-1:0] stored,
  input  wire logic [bsrs_pkg::REC_BITS-1:0] item,
  output bsrs_pkg::cmp_res_t                 res
);
  import bsrs_pkg::*;
  logic [KEY_BITS-1:0] ka, kb;
  assign ka = stored[REC_BITS-1 -: KEY_BITS];
  assign kb = item[REC_BITS-1 -: KEY_BITS];
  // Big-endian byte strings compare as plain unsigned integers.
  assign res.lt = ka < kb;
  assign res.eq = ka == kb;
endmodule
`default_nettype wire

// ===== rtl/bucketed_sorted_record_store.sv =====
// Bucketed sorted record store: binary search plus sorted insert per bucket.
// Each search probe reads an order entry, then the four record words of its
// slot, then compares keys; a command that does not insert, or an insert into
// a full bucket, ends after the last probe. An insert shifts order entries up
// one at a time, then writes the record words, new order entry and count. The result strobe rises
// in the cycle busy falls, so a new word can be taken at that edge.
// Reset (synchronous, rst_n low) runs a pass over all 256 buckets that zeroes the
// bucket counts; busy is high during it. Results cannot be stalled.
`default_nettype none
module bucketed_sorted_record_store (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_bucket,
  input  wire logic [63:0] in_rec_w0,
  input  wire logic [63:0] in_rec_w1,
  input  wire logic [63:0] in_rec_w2,
  input  wire logic [63:0] in_rec_w3,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [6:0]       out_rank,
  output logic [63:0]      out_w0,
  output logic [63:0]      out_w1,
  output logic [63:0]      out_w2,
  output logic [63:0]      out_w3
);
  import bsrs_pkg::*;

  // Sequencer states. Every memory read has registered data, so the address is
  // presented in one state and the data is waited on in a later one.
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CNT   = 4'd2;  // count read data arrives
  localparam logic [3:0] S_PROBE = 4'd3;  // decide next probe or finish
  localparam logic [3:0] S_ORDW  = 4'd4;  // order entry read in flight
  localparam logic [3:0] S_RECW  = 4'd5;  // record word reads in flight
  localparam logic [3:0] S_CHK   = 4'd6;  // compare the fetched record
  localparam logic [3:0] S_SHR   = 4'd7;  // shift: read order[i-1]
  localparam logic [3:0] S_SHW   = 4'd8;  // shift: write order[i]
  localparam logic [3:0] S_INS   = 4'd9;  // write new entry, record, count

  logic [3:0] state_r, state_nxt;

  logic [1:0]              cmd_r;
  logic [BUCKET_BITS-1:0]  bkt_r;
  logic [REC_BITS-1:0]     rec_r;
  logic [CNT_BITS-1:0]     cnt_r, first_r, len_r, step_r, it_r, idx_r;
  logic                    verify_r;  // probe at the final rank for a hit
  logic                    hit_r;
  logic [1:0]              wsel_r;    // record word counter
  logic [REC_BITS-1:0]     fetched_r;
  logic [SLOT_BITS-1:0]    slot_r;
  logic [BUCKET_BITS-1:0]  clr_r;

  // Count memory, 256 entries, cleared by the pass after reset.
  logic                   cnt_we;
  logic [BUCKET_BITS-1:0] cnt_waddr;
  logic [CNT_BITS-1:0]    cnt_wdata, cnt_rdata;
  bsrs_ram #(.WIDTH(CNT_BITS), .DEPTH(NUM_BUCKETS)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(in_bucket[BUCKET_BITS-1:0]), .rdata(cnt_rdata)
  );

  // Sorted order memory holds slot numbers per bucket.
  logic                  ord_we;
  logic [SLOT_BITS-1:0]  ord_wpos, ord_rpos;
  logic [SLOT_BITS-1:0]  ord_wdata, ord_rdata;
  bsrs_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_BUCKETS * BUCKET_CAP)) u_ord (
    .clk, .we(ord_we), .waddr({bkt_r, ord_wpos}), .wdata(ord_wdata),
    .raddr({bkt_r, ord_rpos}), .rdata(ord_rdata)
  );

  // Record memory, one 64-bit word per entry, four words per slot.
  logic                 rec_we;
  logic [63:0]          rec_wdata, rec_rdata;
  logic [REC_ABITS-1:0] rec_raddr;
  assign rec_raddr = {bkt_r, slot_r, wsel_r};
  bsrs_ram #(.WIDTH(64), .DEPTH(NUM_BUCKETS * BUCKET_CAP * 4)) u_rec (
    .clk, .we(rec_we), .waddr({bkt_r, cnt_r[SLOT_BITS-1:0], wsel_r}),
    .wdata(rec_wdata), .raddr(rec_raddr), .rdata(rec_rdata)
  );

  // The last record word lands in the compare cycle, so it is taken straight
  // from the memory output there.
  logic [REC_BITS-1:0] cmp_stored;
  assign cmp_stored = {fetched_r[REC_BITS-1:64], rec_rdata};

  cmp_res_t cmp;
  bsrs_keycmp u_cmp (.stored(cmp_stored), .item(rec_r), .res(cmp));

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Insert happens for add, or find-or-add on a miss, unless the bucket is full.
  logic do_ins;
  assign do_ins = (cmd_r == CMD_ADD) || (cmd_r == CMD_FOA && !hit_r);

  // Probe decisions. A search probe runs while the remaining length is not
  // zero; afterwards, if the final rank is below the count, one more probe at it checks for a match.
  logic [CNT_BITS-1:0] half_len, idx_dec;
  logic                probe_go, verify_go, full_w;
  assign half_len  = len_r >> 1;
  assign idx_dec   = idx_r - CNT_BITS'(1);
  assign probe_go  = !verify_r && (len_r != '0);
  assign verify_go = !verify_r && (len_r == '0) && (first_r < cnt_r);
  assign full_w    = (cnt_r >= CNT_BITS'(BUCKET_CAP));

  always_comb begin
    state_nxt = state_r;
    cnt_we    = 1'b0;
    cnt_waddr = bkt_r;
    cnt_wdata = cnt_r + CNT_BITS'(1);
    ord_we    = 1'b0;
    ord_wpos  = idx_r[SLOT_BITS-1:0];
    ord_wdata = ord_rdata;
    ord_rpos  = '0;
    rec_we    = 1'b0;
    unique case (wsel_r)
      2'd0: rec_wdata = rec_r[255:192];
      2'd1: rec_wdata = rec_r[191:128];
      2'd2: rec_wdata = rec_r[127:64];
      default: rec_wdata = rec_r[63:0];
    endcase
    unique case (state_r)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        if (clr_r == BUCKET_BITS'(NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE:  if (accept) state_nxt = S_CNT;
      S_CNT:   state_nxt = S_PROBE;
      S_PROBE: begin
        priority if (probe_go) begin
          ord_rpos  = SLOT_BITS'(first_r + half_len);
          state_nxt = S_ORDW;
        end else if (verify_go) begin
          ord_rpos  = first_r[SLOT_BITS-1:0];
          state_nxt = S_ORDW;
        end else if (!do_ins || full_w) begin
          state_nxt = S_IDLE;
        end else if (cnt_r == first_r) begin
          state_nxt = S_INS;
        end else begin
          state_nxt = S_SHR;
        end
      end
      S_ORDW:  state_nxt = S_RECW;
      S_RECW:  if (wsel_r == 2'd3) state_nxt = S_CHK;
      S_CHK:   state_nxt = S_PROBE;
      S_SHR: begin
        ord_rpos  = idx_dec[SLOT_BITS-1:0];
        state_nxt = S_SHW;
      end
      S_SHW: begin
        ord_we    = 1'b1;
        state_nxt = (idx_dec == first_r) ? S_INS : S_SHR;
      end
      S_INS: begin
        rec_we = 1'b1;
        if (wsel_r == 2'd3) begin
          ord_we    = 1'b1;
          ord_wpos  = first_r[SLOT_BITS-1:0];
          ord_wdata = cnt_r[SLOT_BITS-1:0];
          cnt_we    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      unique case (state_r)
        S_CLR: clr_r <= clr_r + BUCKET_BITS'(1);
        S_IDLE: begin
          if (accept) begin
            cmd_r <= in_cmd;
            bkt_r <= in_bucket[BUCKET_BITS-1:0];
            rec_r <= {in_rec_w0, in_rec_w1, in_rec_w2, in_rec_w3};
          end
        end
        S_CNT: begin
          // The count was addressed from in_bucket at accept and arrives in the next cycle.
          cnt_r    <= cnt_rdata;
          len_r    <= cnt_rdata;
          first_r  <= '0;
          verify_r <= 1'b0;
          hit_r    <= 1'b0;
        end
        S_PROBE: begin
          wsel_r <= '0;
          priority if (probe_go) begin
            step_r <= half_len;
            it_r   <= first_r + half_len;
          end else if (verify_go) begin
            verify_r <= 1'b1;
            it_r     <= first_r;
          end else begin
            idx_r <= cnt_r;
            if (do_ins && full_w) begin
              out_valid  <= 1'b1;
              out_status <= ST_FULL;
              out_rank   <= 7'(first_r);
              {out_w0, out_w1, out_w2, out_w3} <= '0;
            end else if (!do_ins) begin
              out_valid  <= 1'b1;
              out_status <= hit_r ? ST_FOUND : ST_MISS;
              out_rank   <= 7'(first_r);
              {out_w0, out_w1, out_w2, out_w3} <= hit_r ? fetched_r : '0;
            end
          end
        end
        S_ORDW: slot_r <= ord_rdata;
        S_RECW: begin
          // Data for the word addressed in the previous cycle lands here.
          wsel_r <= wsel_r + 2'd1;
          unique case (wsel_r)
            2'd1: fetched_r[255:192] <= rec_rdata;
            2'd2: fetched_r[191:128] <= rec_rdata;
            2'd3: fetched_r[127:64]  <= rec_rdata;
            default: ;
          endcase
        end
        S_CHK: begin
          fetched_r[63:0] <= rec_rdata;
          if (verify_r) begin
            hit_r <= cmp.eq;
            len_r <= '0;
          end else if (cmp.lt) begin
            first_r <= it_r + CNT_BITS'(1);
            len_r   <= len_r - step_r - CNT_BITS'(1);
          end else begin
            len_r <= step_r;
          end
        end
        S_SHR: ;
        S_SHW: idx_r <= idx_dec;
        S_INS: begin
          wsel_r <= wsel_r + 2'd1;
          if (wsel_r == 2'd3) begin
            out_valid  <= 1'b1;
            out_status <= ST_ADDED;
            out_rank   <= 7'(first_r);
            {out_w0, out_w1, out_w2, out_w3} <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
